>>> rtl/fpsm_pkg.sv
// ----------------------------------------------------------------------------
// fpsm_pkg
// shared sizes, codes and types of the floating-point register stack mapper
// ----------------------------------------------------------------------------
package fpsm_pkg;

	localparam int STACK_SLOTS  = 8;
	localparam int VIRTUAL_REGS = 8;

	localparam int POS_W     = $clog2(STACK_SLOTS);
	localparam int DEPTH_W   = $clog2(STACK_SLOTS + 1);
	localparam int REG_W     = 3;
	localparam int CMD_W     = 3;
	localparam int LIVE_W    = 8;
	localparam int KIND_W    = 4;
	localparam int OUT_POS_W = 3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// command codes on the input word
	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNARY  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BINARY = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STORE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COPY   = 3'd4;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_UNARY,
		OP_BINARY,
		OP_STORE,
		OP_COPY,
		OP_BAD
	} op_t;

	// decoded instruction as it sits in the queue
	typedef struct packed {
		op_t              op;
		logic [REG_W-1:0] r1;
		logic [REG_W-1:0] r2;
		logic             in_reg;
		logic [REG_W-1:0] rd;
		logic             rd_ok;
		logic             l1;
		logic             l2;
	} item_t;

	typedef enum logic [KIND_W-1:0] {
		K_XCHG      = 4'd0,
		K_PUSH      = 4'd1,
		K_LOAD      = 4'd2,
		K_UNARY     = 4'd3,
		K_BINOP     = 4'd4,
		K_BINOP_POP = 4'd5,
		K_REV_POP   = 4'd6,
		K_STORE     = 4'd7,
		K_STORE_POP = 4'd8,
		K_COPY_DEAD = 4'd9,
		K_ERROR     = 4'd10
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [OUT_POS_W-1:0] pos_a;
		logic [OUT_POS_W-1:0] pos_b;
		logic [OUT_POS_W-1:0] pos_out;
	} result_t;

endpackage

>>> rtl/fp_register_stack_mapper.sv
// ----------------------------------------------------------------------------
// fp_register_stack_mapper
// maps virtual floating-point instructions onto an 8-slot register stack
// ----------------------------------------------------------------------------
// start is taken at a rising edge where busy is low; the instruction word goes
// into a two-entry queue, so busy rises only when that queue is full. the back
// end takes one instruction from the queue per plan cycle and emits one or two
// result words, each shown for exactly one cycle with strobe high: an optional
// fix-up (exchange with top or push of a copy) and then the rewritten
// instruction, or a single error word. last marks the final word. results
// cannot be held off, so the receiver must take every strobed word. an
// instruction with a fix-up blocks the planning of the next one while its
// second word is pending; the first word appears in the cycle after the plan
// cycle, and an instruction that reaches an idle, empty block is planned in
// the cycle after it is taken. throughput is set by the single stack update
// per plan cycle, since each instruction depends on the stack left by the one
// before. no clearing pass: the stack depth resets to empty and slot contents
// are only read inside the depth.
// ----------------------------------------------------------------------------
module fp_register_stack_mapper (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [fpsm_pkg::CMD_W-1:0]      command,
	input  logic [fpsm_pkg::REG_W-1:0]      first_source,
	input  logic [fpsm_pkg::REG_W-1:0]      second_source,
	input  logic                            second_in_register,
	input  logic [fpsm_pkg::REG_W-1:0]      destination,
	input  logic [fpsm_pkg::LIVE_W-1:0]     live_after,
	output logic                            strobe,
	output logic [fpsm_pkg::KIND_W-1:0]     kind,
	output logic [fpsm_pkg::OUT_POS_W-1:0]  position_a,
	output logic [fpsm_pkg::OUT_POS_W-1:0]  position_b,
	output logic [fpsm_pkg::OUT_POS_W-1:0]  position_out,
	output logic                            last
);
	import fpsm_pkg::*;

	logic  accept;
	logic  queue_full;
	logic  head_valid;
	logic  head_pop;
	item_t in_item;
	item_t head_item;

	// front: accept and classify the incoming word
	fpsm_front u_front (
		.start              (start),
		.queue_full         (queue_full),
		.command            (command),
		.first_source       (first_source),
		.second_source      (second_source),
		.second_in_register (second_in_register),
		.destination        (destination),
		.live_after         (live_after),
		.accept             (accept),
		.item               (in_item)
	);

	// decoupling queue
	fpsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.din        (in_item),
		.pop        (head_pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head_item)
	);

	// back: stack state, planning and result words
	fpsm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head_item),
		.head_pop     (head_pop),
		.strobe       (strobe),
		.kind         (kind),
		.position_a   (position_a),
		.position_b   (position_b),
		.position_out (position_out),
		.last         (last)
	);

	assign busy = queue_full;

endmodule

>>> rtl/fpsm_front.sv
// ----------------------------------------------------------------------------
// fpsm_front
// takes instruction words and classifies them for the back end
// ----------------------------------------------------------------------------
module fpsm_front (
	input  logic                         start,
	input  logic                         queue_full,
	input  logic [fpsm_pkg::CMD_W-1:0]   command,
	input  logic [fpsm_pkg::REG_W-1:0]   first_source,
	input  logic [fpsm_pkg::REG_W-1:0]   second_source,
	input  logic                         second_in_register,
	input  logic [fpsm_pkg::REG_W-1:0]   destination,
	input  logic [fpsm_pkg::LIVE_W-1:0]  live_after,
	output logic                         accept,
	output fpsm_pkg::item_t              item
);
	import fpsm_pkg::*;

	assign accept = start && !queue_full;

	always_comb begin
		item.r1     = first_source;
		item.r2     = second_source;
		item.in_reg = second_in_register;
		item.rd     = destination;
		item.rd_ok  = (32'(destination) < VIRTUAL_REGS);
		item.l1     = live_after[first_source];
		item.l2     = live_after[second_source];
		unique case (command)
			CMD_LOAD:   item.op = OP_LOAD;
			CMD_UNARY:  item.op = OP_UNARY;
			CMD_BINARY: item.op = OP_BINARY;
			CMD_STORE:  item.op = OP_STORE;
			CMD_COPY:   item.op = OP_COPY;
			default:    item.op = OP_BAD;
		endcase
	end

endmodule

>>> rtl/fpsm_queue.sv
// ----------------------------------------------------------------------------
// fpsm_queue
// short fifo of decoded instructions between front and back end
// ----------------------------------------------------------------------------
module fpsm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fpsm_pkg::item_t din,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output fpsm_pkg::item_t head
);
	import fpsm_pkg::*;

	item_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push && !full)
			entry_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if ((push && !full) && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!(push && !full) && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!head_valid && !push) |=> !head_valid)
		else $error("queue became valid without a write");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> full)
		else $error("full queue lost an entry without a read");

endmodule

>>> rtl/fpsm_back.sv
// ----------------------------------------------------------------------------
// fpsm_back
// keeps the register stack, plans fix-up and rewritten instruction, emits them
// ----------------------------------------------------------------------------
module fpsm_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  fpsm_pkg::item_t                 head,
	output logic                            head_pop,
	output logic                            strobe,
	output logic [fpsm_pkg::KIND_W-1:0]     kind,
	output logic [fpsm_pkg::OUT_POS_W-1:0]  position_a,
	output logic [fpsm_pkg::OUT_POS_W-1:0]  position_b,
	output logic [fpsm_pkg::OUT_POS_W-1:0]  position_out,
	output logic                            last
);
	import fpsm_pkg::*;

	// stack kept in position order: entry 0 is the top
	logic [REG_W-1:0]   st_q [STACK_SLOTS];
	logic [DEPTH_W-1:0] depth_q;

	logic               pend_q;
	result_t            pend_res_q;
	logic               strobe_q;
	result_t            out_q;
	logic               last_q;

	logic               hit1, hit2;
	logic [POS_W-1:0]   i1, i2;
	logic               full;

	logic               plan_go;
	logic               plan_ok;
	logic               fix;
	result_t            fix_res, main_res;
	logic               do_push, do_xchg, do_write, do_pop;
	logic [POS_W-1:0]   xp, wpos;
	logic [POS_W-1:0]   pa, pb, oi;
	kind_t              k;

	logic [REG_W-1:0]   after1 [STACK_SLOTS];
	logic [REG_W-1:0]   after2 [STACK_SLOTS];
	logic [REG_W-1:0]   ns     [STACK_SLOTS];
	logic [DEPTH_W-1:0] nd;
	logic [REG_W-1:0]   xval;

	function automatic result_t mk(kind_t kk, logic [POS_W-1:0] a, logic [POS_W-1:0] b,
			logic [POS_W-1:0] o);
		result_t r;
		r.kind    = kk;
		r.pos_a   = OUT_POS_W'(a);
		r.pos_b   = OUT_POS_W'(b);
		r.pos_out = OUT_POS_W'(o);
		return r;
	endfunction

	assign full     = (depth_q == DEPTH_W'(STACK_SLOTS));
	assign plan_go  = head_valid && !pend_q;
	assign head_pop = plan_go;

	// operand search, lowest position wins
	always_comb begin
		hit1 = 1'b0;
		hit2 = 1'b0;
		i1   = '0;
		i2   = '0;
		for (int i = STACK_SLOTS - 1; i >= 0; i--) begin
			if ((DEPTH_W'(i) < depth_q) && (st_q[i] == head.r1)) begin
				hit1 = 1'b1;
				i1   = POS_W'(i);
			end
			if ((DEPTH_W'(i) < depth_q) && (st_q[i] == head.r2)) begin
				hit2 = 1'b1;
				i2   = POS_W'(i);
			end
		end
	end

	// plan of one instruction
	always_comb begin
		plan_ok  = 1'b1;
		fix      = 1'b0;
		fix_res  = mk(K_XCHG, '0, '0, '0);
		main_res = mk(K_ERROR, '0, '0, '0);
		do_push  = 1'b0;
		do_xchg  = 1'b0;
		do_write = 1'b0;
		do_pop   = 1'b0;
		xp       = '0;
		wpos     = '0;
		pa       = i1;
		pb       = i2;
		oi       = '0;
		k        = K_BINOP;
		unique case (head.op)
			OP_LOAD: begin
				if (!head.rd_ok || full)
					plan_ok = 1'b0;
				else begin
					do_push  = 1'b1;
					main_res = mk(K_LOAD, '0, '0, '0);
				end
			end
			OP_UNARY: begin
				if (!head.rd_ok || !hit1)
					plan_ok = 1'b0;
				else if (head.l1) begin
					if (full)
						plan_ok = 1'b0;
					else begin
						do_push = 1'b1;
						fix     = 1'b1;
						fix_res = mk(K_PUSH, i1, '0, '0);
					end
				end else begin
					if (i1 != '0) begin
						do_xchg = 1'b1;
						xp      = i1;
						fix     = 1'b1;
						fix_res = mk(K_XCHG, i1, '0, '0);
					end
					do_write = 1'b1;
				end
				main_res = mk(K_UNARY, '0, '0, '0);
			end
			OP_BINARY: begin
				if (!head.rd_ok || !hit1 || (head.in_reg && !hit2))
					plan_ok = 1'b0;
				else if (head.in_reg) begin
					if (head.l1 && head.l2) begin
						if (full)
							plan_ok = 1'b0;
						else begin
							do_push = 1'b1;
							fix     = 1'b1;
							fix_res = mk(K_PUSH, i1, '0, '0);
							pa      = '0;
							pb      = i2 + 1'b1;
						end
					end else if (head.l1) begin
						if (i2 != '0) begin
							do_xchg = 1'b1;
							xp      = i2;
							fix     = 1'b1;
							fix_res = mk(K_XCHG, i2, '0, '0);
							if (i1 == '0)
								pa = i2;
						end
						pb = '0;
					end else if (head.l2) begin
						if (i1 != '0) begin
							do_xchg = 1'b1;
							xp      = i1;
							fix     = 1'b1;
							fix_res = mk(K_XCHG, i1, '0, '0);
							if (i2 == '0)
								pb = i1;
						end
						pa = '0;
					end else begin
						// both operands die: pop variant
						do_pop = 1'b1;
						if (i1 == '0) begin
							oi = i2;
							pa = i2;
							pb = '0;
							k  = K_REV_POP;
						end else if (i2 == '0) begin
							oi = i1;
							k  = K_BINOP_POP;
						end else begin
							do_xchg = 1'b1;
							xp      = i2;
							fix     = 1'b1;
							fix_res = mk(K_XCHG, i2, '0, '0);
							pb      = '0;
							oi      = i1;
							k       = K_BINOP_POP;
						end
					end
				end else begin
					// memory operand
					if (head.l1) begin
						if (full)
							plan_ok = 1'b0;
						else begin
							do_push = 1'b1;
							fix     = 1'b1;
							fix_res = mk(K_PUSH, i1, '0, '0);
						end
					end else if (i1 != '0) begin
						do_xchg = 1'b1;
						xp      = i1;
						fix     = 1'b1;
						fix_res = mk(K_XCHG, i1, '0, '0);
					end
					pa = '0;
					pb = '0;
				end
				do_write = 1'b1;
				wpos     = oi;
				main_res = mk(k, pa, pb, oi);
			end
			OP_STORE: begin
				if (!hit2)
					plan_ok = 1'b0;
				else begin
					if (i2 != '0) begin
						do_xchg = 1'b1;
						xp      = i2;
						fix     = 1'b1;
						fix_res = mk(K_XCHG, i2, '0, '0);
					end
					if (head.l2)
						main_res = mk(K_STORE, '0, '0, '0);
					else begin
						do_pop   = 1'b1;
						main_res = mk(K_STORE_POP, '0, '0, '0);
					end
				end
			end
			OP_COPY: begin
				if (!head.rd_ok || !hit1)
					plan_ok = 1'b0;
				else if (head.l1) begin
					if (full)
						plan_ok = 1'b0;
					else begin
						do_push  = 1'b1;
						main_res = mk(K_PUSH, i1, '0, '0);
					end
				end else begin
					do_write = 1'b1;
					wpos     = i1;
					main_res = mk(K_COPY_DEAD, i1, '0, i1);
				end
			end
			default: plan_ok = 1'b0;
		endcase
		if (!plan_ok) begin
			fix      = 1'b0;
			main_res = mk(K_ERROR, '0, '0, '0);
		end
	end

	// next stack: push or exchange, then destination write, then pop
	assign xval = st_q[xp];

	always_comb begin
		for (int i = 0; i < STACK_SLOTS; i++) begin
			if (do_push)
				after1[i] = (i == 0) ? head.rd : st_q[(i == 0) ? 0 : i - 1];
			else if (do_xchg && (i == 0))
				after1[i] = xval;
			else if (do_xchg && (POS_W'(i) == xp))
				after1[i] = st_q[0];
			else
				after1[i] = st_q[i];
			after2[i] = (do_write && (POS_W'(i) == wpos)) ? head.rd : after1[i];
		end
		for (int i = 0; i < STACK_SLOTS; i++) begin
			if (do_pop && (i < STACK_SLOTS - 1))
				ns[i] = after2[(i < STACK_SLOTS - 1) ? i + 1 : i];
			else
				ns[i] = after2[i];
		end
		if (do_push)
			nd = depth_q + 1'b1;
		else if (do_pop && (depth_q != '0))
			nd = depth_q - 1'b1;
		else
			nd = depth_q;
	end

	always_ff @(posedge clk) begin
		if (plan_go && plan_ok)
			st_q <= ns;
		if (plan_go) begin
			out_q      <= fix ? fix_res : main_res;
			pend_res_q <= main_res;
		end else if (pend_q)
			out_q <= pend_res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (plan_go && plan_ok)
				depth_q <= nd;
			if (plan_go) begin
				strobe_q <= 1'b1;
				last_q   <= !fix;
				pend_q   <= fix;
			end else if (pend_q) begin
				strobe_q <= 1'b1;
				last_q   <= 1'b1;
				pend_q   <= 1'b0;
			end else begin
				strobe_q <= 1'b0;
				last_q   <= 1'b0;
			end
		end
	end

	assign strobe       = strobe_q;
	assign kind         = out_q.kind;
	assign position_a   = out_q.pos_a;
	assign position_b   = out_q.pos_b;
	assign position_out = out_q.pos_out;
	assign last         = last_q;

	a_pend_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> (strobe_q && last_q))
		else $error("second word of an instruction not delivered");
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_SLOTS))
		else $error("stack depth beyond slot count");
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (out_q.kind == K_ERROR)) |-> (last_q && (out_q.pos_a == '0)
			&& (out_q.pos_b == '0) && (out_q.pos_out == '0)))
		else $error("malformed error word");
	a_depth_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(depth_q) |-> $past(plan_go && plan_ok))
		else $error("stack depth moved without a committed instruction");

endmodule
